/* design/dirty_position_bitmap_unit_defines.svh */
// ----------------------------------------------------------------------------
// Dirty position bitmap unit - assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DIRTY_POSITION_BITMAP_UNIT_DEFINES_SVH
`define DIRTY_POSITION_BITMAP_UNIT_DEFINES_SVH

// same-cycle implication
`define DPB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dpb_pkg.sv */
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared types, constants and sizing helpers of the dirty position bitmap.
// ----------------------------------------------------------------------------
package dpb_pkg;

    localparam int WORD_BITS     = 64;
    localparam int DEF_POSITIONS = 65536;

    typedef enum logic [1:0] {
        CMD_MARK  = 2'd0,
        CMD_SNAP  = 2'd1,
        CMD_TAKE  = 2'd2,
        CMD_MERGE = 2'd3
    } t_cmd;

    function automatic int map_words(int positions);
        return (positions + WORD_BITS - 1) / WORD_BITS;
    endfunction

    function automatic int addr_bits(int positions);
        return (map_words(positions) > 1) ? $clog2(map_words(positions)) : 1;
    endfunction

endpackage

/* design/dirty_position_bitmap_unit.sv */
// ----------------------------------------------------------------------------
// dirty_position_bitmap_unit
// Live dirty bitmap with snapshot into a drain copy and ascending hand-out.
//
// Channel  | Dir | Signals                                         | Handshake
// ---------+-----+-------------------------------------------------+----------------------
// command  | in  | i_cmd i_start_req i_count i_word_index          | start && !busy
//          |     | i_word_data                                     |
// result   | out | o_position o_position_valid o_last_of_batch     | o_done, one cycle
//          |     | o_processing o_live_empty o_overflow            |
//
// Mark and merge read-modify-write each live word they touch. Snapshot
// sweeps both memories, ORing live into drain and clearing live; take scans
// drain words upward to the first dirty one; items with no memory work skip the sweep.
// The word memories have one read and one write port; each sweep moves one
// word per cycle. After reset a clearing pass over all MAP_WORDS words holds busy.
// Results are never stalled; busy drops in the cycle o_done is shown.
// ----------------------------------------------------------------------------
module dirty_position_bitmap_unit #(
    parameter int POSITIONS = dpb_pkg::DEF_POSITIONS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic [15:0]                   i_start_req,
    input  logic [16:0]                   i_count,
    input  logic [9:0]                    i_word_index,
    input  logic [dpb_pkg::WORD_BITS-1:0] i_word_data,
    output logic                          o_done,
    output logic [15:0]                   o_position,
    output logic                          o_position_valid,
    output logic                          o_last_of_batch,
    output logic                          o_processing,
    output logic                          o_live_empty,
    output logic                          o_overflow
);
    import dpb_pkg::*;

    localparam int MAP_WORDS = map_words(POSITIONS);
    localparam int AW        = addr_bits(POSITIONS);

    logic [AW-1:0]        raddr, waddr;
    logic                 live_we, drain_we;
    logic [WORD_BITS-1:0] live_wdata, live_rdata, drain_wdata, drain_rdata;

    dpb_ctrl #(
        .POSITIONS (POSITIONS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_start_req      (i_start_req),
        .i_count          (i_count),
        .i_word_index     (i_word_index),
        .i_word_data      (i_word_data),
        .o_done           (o_done),
        .o_position       (o_position),
        .o_position_valid (o_position_valid),
        .o_last_of_batch  (o_last_of_batch),
        .o_processing     (o_processing),
        .o_live_empty     (o_live_empty),
        .o_overflow       (o_overflow),
        .o_raddr          (raddr),
        .o_waddr          (waddr),
        .o_live_we        (live_we),
        .o_live_wdata     (live_wdata),
        .i_live_rdata     (live_rdata),
        .o_drain_we       (drain_we),
        .o_drain_wdata    (drain_wdata),
        .i_drain_rdata    (drain_rdata)
    );

    dpb_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (live_we),
        .i_waddr (waddr),
        .i_wdata (live_wdata),
        .i_raddr (raddr),
        .o_rdata (live_rdata)
    );

    dpb_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_drain_ram (
        .i_clk   (i_clk),
        .i_we    (drain_we),
        .i_waddr (waddr),
        .i_wdata (drain_wdata),
        .i_raddr (raddr),
        .o_rdata (drain_rdata)
    );

endmodule

/* design/dpb_ram.sv */
// ----------------------------------------------------------------------------
// dpb_ram
// One-write one-read bitmap word memory, registered read data.
// ----------------------------------------------------------------------------
module dpb_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [dpb_pkg::WORD_BITS-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [dpb_pkg::WORD_BITS-1:0] o_rdata
);
    import dpb_pkg::*;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/dpb_ctrl.sv */
// ----------------------------------------------------------------------------
// dpb_ctrl
// Command sequencer: clearing pass, read-modify-write sweeps over the live
// and drain memories, popcount accumulation and next-dirty scan.
// ----------------------------------------------------------------------------
module dpb_ctrl #(
    parameter int  POSITIONS = dpb_pkg::DEF_POSITIONS,
    localparam int MAP_WORDS = dpb_pkg::map_words(POSITIONS),
    localparam int AW        = dpb_pkg::addr_bits(POSITIONS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic [15:0]                   i_start_req,
    input  logic [16:0]                   i_count,
    input  logic [9:0]                    i_word_index,
    input  logic [dpb_pkg::WORD_BITS-1:0] i_word_data,
    output logic                          o_done,
    output logic [15:0]                   o_position,
    output logic                          o_position_valid,
    output logic                          o_last_of_batch,
    output logic                          o_processing,
    output logic                          o_live_empty,
    output logic                          o_overflow,
    output logic [AW-1:0]                 o_raddr,
    output logic [AW-1:0]                 o_waddr,
    output logic                          o_live_we,
    output logic [dpb_pkg::WORD_BITS-1:0] o_live_wdata,
    input  logic [dpb_pkg::WORD_BITS-1:0] i_live_rdata,
    output logic                          o_drain_we,
    output logic [dpb_pkg::WORD_BITS-1:0] o_drain_wdata,
    input  logic [dpb_pkg::WORD_BITS-1:0] i_drain_rdata
);
    import dpb_pkg::*;

    localparam int LW  = $clog2(WORD_BITS);
    localparam int CW  = $clog2(MAP_WORDS + 1);
    localparam int RW  = $clog2(POSITIONS + 1);
    localparam int EW  = (AW + LW + 1 > 18) ? AW + LW + 1 : 18;
    localparam int REM = POSITIONS % WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        (REM == 0) ? '1 : ((WORD_BITS'(1) << REM) - WORD_BITS'(1));
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [EW-1:0] POS_LIMIT = EW'(POSITIONS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SNAP,
        ST_SCAN
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_issue_addr, n_issue_addr;
    logic [AW-1:0]         r_end_addr, n_end_addr;
    logic [AW-1:0]         r_first_addr, n_first_addr;
    logic                  r_issuing, n_issuing;
    logic                  r_pend, n_pend;
    logic [AW-1:0]         r_pend_addr, n_pend_addr;
    logic [LW-1:0]         r_lo, n_lo;
    logic [LW-1:0]         r_hi, n_hi;
    logic                  r_merge, n_merge;
    logic [WORD_BITS-1:0]  r_bits, n_bits;
    logic                  r_ovf_hold, n_ovf_hold;
    logic [LW:0]           r_pop, n_pop;
    logic                  r_pop_v, n_pop_v;
    logic                  r_pop_last, n_pop_last;
    logic [RW-1:0]         r_acc, n_acc;
    logic [AW-1:0]         r_scan_word, n_scan_word;
    logic                  r_busy_flag, n_busy_flag;
    logic [CW-1:0]         r_live_cnt, n_live_cnt;
    logic [RW-1:0]         r_remaining, n_remaining;
    logic                  r_done, n_done;
    logic [15:0]           r_position, n_position;
    logic                  r_pvalid, n_pvalid;
    logic                  r_last, n_last;
    logic                  r_ovf, n_ovf;

    // item decode
    logic [EW-1:0]         m_start, m_count, m_end, m_endc, m_last;
    logic                  m_ovf, m_act;
    logic [AW+9:0]         widx_ext;
    logic                  merge_ok;
    logic [WORD_BITS-1:0]  merge_mask, merge_keep;
    logic                  merge_drop;

    // word datapath
    logic [LW-1:0]         lo_sel, hi_sel;
    logic [WORD_BITS-1:0]  mark_mask, rmw_bits, live_new, drain_or, drain_clr, iso;
    logic [LW-1:0]         low_idx;
    logic [LW:0]           pop_cnt;
    logic [AW+LW+15:0]     pos_wide;
    logic [RW-1:0]         snap_total;

    logic [1:0]            pc1 [32];
    logic [2:0]            pc2 [16];
    logic [3:0]            pc3 [8];
    logic [4:0]            pc4 [4];
    logic [5:0]            pc5 [2];

    // result staging
    logic                  res_fire, res_pv, res_last, res_ovf;
    logic [15:0]           res_pos;

    always_comb begin
        m_start    = EW'(i_start_req);
        m_count    = EW'(i_count);
        m_end      = m_start + m_count;
        m_ovf      = (i_count != 17'd0) && (m_end > POS_LIMIT);
        m_endc     = m_ovf ? POS_LIMIT : m_end;
        m_act      = (i_count != 17'd0) && (m_start < m_endc);
        m_last     = m_endc - EW'(1);
        widx_ext   = {{AW{1'b0}}, i_word_index};
        merge_ok   = 32'(i_word_index) < 32'(MAP_WORDS);
        merge_mask = (widx_ext[AW-1:0] == LAST_WORD) ? LAST_MASK : '1;
        merge_keep = i_word_data & merge_mask;
        merge_drop = |(i_word_data & ~merge_mask);
    end

    always_comb begin
        lo_sel    = (r_pend_addr == r_first_addr) ? r_lo : '0;
        hi_sel    = (r_pend_addr == r_end_addr) ? r_hi : '1;
        mark_mask = ({WORD_BITS{1'b1}} << lo_sel)
                  & ({WORD_BITS{1'b1}} >> (LW'(WORD_BITS - 1) - hi_sel));
        rmw_bits  = r_merge ? r_bits : mark_mask;
        live_new  = i_live_rdata | rmw_bits;
        drain_or  = i_drain_rdata | i_live_rdata;
        drain_clr = i_drain_rdata & (i_drain_rdata - WORD_BITS'(1));
        iso       = i_drain_rdata & (~i_drain_rdata + WORD_BITS'(1));
        pos_wide  = {16'd0, r_pend_addr, low_idx};
        snap_total = r_acc + RW'(r_pop);
    end

    // one-hot lowest bit to index
    always_comb begin
        low_idx = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (iso[j]) begin
                low_idx = low_idx | LW'(j);
            end
        end
    end

    // popcount tree of the merged drain word
    always_comb begin
        for (int i = 0; i < 32; i++) begin
            pc1[i] = {1'b0, drain_or[2*i]} + {1'b0, drain_or[2*i+1]};
        end
        for (int i = 0; i < 16; i++) begin
            pc2[i] = {1'b0, pc1[2*i]} + {1'b0, pc1[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            pc3[i] = {1'b0, pc2[2*i]} + {1'b0, pc2[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            pc4[i] = {1'b0, pc3[2*i]} + {1'b0, pc3[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            pc5[i] = {1'b0, pc4[2*i]} + {1'b0, pc4[2*i+1]};
        end
        pop_cnt = {1'b0, pc5[0]} + {1'b0, pc5[1]};
    end

    always_comb begin
        n_state      = r_state;
        n_issue_addr = r_issue_addr;
        n_end_addr   = r_end_addr;
        n_first_addr = r_first_addr;
        n_issuing    = r_issuing;
        n_pend       = 1'b0;
        n_pend_addr  = r_pend_addr;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_merge      = r_merge;
        n_bits       = r_bits;
        n_ovf_hold   = r_ovf_hold;
        n_pop        = r_pop;
        n_pop_v      = 1'b0;
        n_pop_last   = 1'b0;
        n_acc        = r_acc;
        n_scan_word  = r_scan_word;
        n_busy_flag  = r_busy_flag;
        n_live_cnt   = r_live_cnt;
        n_remaining  = r_remaining;
        n_done       = 1'b0;
        n_position   = r_position;
        n_pvalid     = r_pvalid;
        n_last       = r_last;
        n_ovf        = r_ovf;

        res_fire = 1'b0;
        res_pv   = 1'b0;
        res_last = 1'b0;
        res_ovf  = 1'b0;
        res_pos  = '0;

        o_raddr       = r_issue_addr;
        o_waddr       = (r_state == ST_CLEAR) ? r_issue_addr : r_pend_addr;
        o_live_we     = 1'b0;
        o_live_wdata  = '0;
        o_drain_we    = 1'b0;
        o_drain_wdata = '0;

        // sweep address issue, data comes back in the following cycle
        if (r_state == ST_RMW || r_state == ST_SNAP || r_state == ST_SCAN) begin
            if (r_issuing) begin
                n_pend      = 1'b1;
                n_pend_addr = r_issue_addr;
                if (r_issue_addr == r_end_addr) begin
                    n_issuing = 1'b0;
                end else begin
                    n_issue_addr = r_issue_addr + AW'(1);
                end
            end
        end

        unique case (r_state)
            ST_CLEAR: begin
                o_live_we  = 1'b1;
                o_drain_we = 1'b1;
                if (r_issue_addr == LAST_WORD) begin
                    n_issue_addr = '0;
                    n_state      = ST_IDLE;
                end else begin
                    n_issue_addr = r_issue_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (start) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_MARK: begin
                            n_ovf_hold = m_ovf;
                            if (m_act) begin
                                n_first_addr = m_start[AW+LW-1:LW];
                                n_issue_addr = m_start[AW+LW-1:LW];
                                n_end_addr   = m_last[AW+LW-1:LW];
                                n_lo         = m_start[LW-1:0];
                                n_hi         = m_last[LW-1:0];
                                n_merge      = 1'b0;
                                n_issuing    = 1'b1;
                                n_state      = ST_RMW;
                            end else begin
                                res_fire = 1'b1;
                                res_ovf  = m_ovf;
                            end
                        end
                        CMD_MERGE: begin
                            if (merge_ok) begin
                                n_first_addr = widx_ext[AW-1:0];
                                n_issue_addr = widx_ext[AW-1:0];
                                n_end_addr   = widx_ext[AW-1:0];
                                n_bits       = merge_keep;
                                n_merge      = 1'b1;
                                n_ovf_hold   = merge_drop;
                                n_issuing    = 1'b1;
                                n_state      = ST_RMW;
                            end else begin
                                res_fire = 1'b1;
                                res_ovf  = |i_word_data;
                            end
                        end
                        CMD_SNAP: begin
                            if (r_live_cnt != '0) begin
                                n_issue_addr = '0;
                                n_end_addr   = LAST_WORD;
                                n_acc        = '0;
                                n_issuing    = 1'b1;
                                n_state      = ST_SNAP;
                            end else begin
                                res_fire = 1'b1;
                            end
                        end
                        CMD_TAKE: begin
                            if (r_remaining != '0) begin
                                n_issue_addr = r_scan_word;
                                n_end_addr   = LAST_WORD;
                                n_issuing    = 1'b1;
                                n_state      = ST_SCAN;
                            end else begin
                                n_busy_flag = 1'b0;
                                res_fire    = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_RMW: begin
                if (r_pend) begin
                    o_live_we    = 1'b1;
                    o_live_wdata = live_new;
                    if (i_live_rdata == '0 && rmw_bits != '0) begin
                        n_live_cnt = r_live_cnt + CW'(1);
                    end
                    if (r_pend_addr == r_end_addr) begin
                        res_fire = 1'b1;
                        res_ovf  = r_ovf_hold;
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_SNAP: begin
                n_pop_v    = r_pend;
                n_pop      = pop_cnt;
                n_pop_last = r_pend && (r_pend_addr == r_end_addr);
                if (r_pend) begin
                    o_drain_we    = 1'b1;
                    o_drain_wdata = drain_or;
                    o_live_we     = 1'b1;
                end
                if (r_pop_v) begin
                    n_acc = snap_total;
                    if (r_pop_last) begin
                        n_remaining = snap_total;
                        n_busy_flag = (snap_total != '0);
                        n_scan_word = '0;
                        n_live_cnt  = '0;
                        res_fire    = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (r_pend) begin
                    if (i_drain_rdata != '0) begin
                        o_drain_we    = 1'b1;
                        o_drain_wdata = drain_clr;
                        n_issuing     = 1'b0;
                        n_pend        = 1'b0;
                        n_remaining   = r_remaining - RW'(1);
                        res_fire      = 1'b1;
                        res_pv        = 1'b1;
                        res_pos       = pos_wide[15:0];
                        if (r_remaining == RW'(1)) begin
                            res_last    = 1'b1;
                            n_busy_flag = 1'b0;
                            n_scan_word = '0;
                        end else begin
                            n_scan_word = r_pend_addr;
                        end
                        n_state = ST_IDLE;
                    end else if (r_pend_addr == r_end_addr) begin
                        n_remaining = '0;
                        n_busy_flag = 1'b0;
                        n_scan_word = '0;
                        res_fire    = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (res_fire) begin
            n_done     = 1'b1;
            n_position = res_pos;
            n_pvalid   = res_pv;
            n_last     = res_last;
            n_ovf      = res_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_issue_addr <= '0;
            r_issuing    <= 1'b0;
            r_pend       <= 1'b0;
            r_pop_v      <= 1'b0;
            r_pop_last   <= 1'b0;
            r_scan_word  <= '0;
            r_busy_flag  <= 1'b0;
            r_live_cnt   <= '0;
            r_remaining  <= '0;
            r_done       <= 1'b0;
            r_pvalid     <= 1'b0;
            r_last       <= 1'b0;
            r_ovf        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue_addr <= n_issue_addr;
            r_issuing    <= n_issuing;
            r_pend       <= n_pend;
            r_pop_v      <= n_pop_v;
            r_pop_last   <= n_pop_last;
            r_scan_word  <= n_scan_word;
            r_busy_flag  <= n_busy_flag;
            r_live_cnt   <= n_live_cnt;
            r_remaining  <= n_remaining;
            r_done       <= n_done;
            r_pvalid     <= n_pvalid;
            r_last       <= n_last;
            r_ovf        <= n_ovf;
            r_end_addr   <= n_end_addr;
            r_first_addr <= n_first_addr;
            r_pend_addr  <= n_pend_addr;
            r_lo         <= n_lo;
            r_hi         <= n_hi;
            r_merge      <= n_merge;
            r_bits       <= n_bits;
            r_ovf_hold   <= n_ovf_hold;
            r_pop        <= n_pop;
            r_acc        <= n_acc;
            r_position   <= n_position;
        end
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_done           = r_done;
    assign o_position       = r_position;
    assign o_position_valid = r_pvalid;
    assign o_last_of_batch  = r_last;
    assign o_overflow       = r_ovf;
    assign o_processing     = r_busy_flag;
    assign o_live_empty     = (r_live_cnt == '0);

endmodule

/* design/dpb_checker.sv */
// ----------------------------------------------------------------------------
// dpb_checker
// Port-level checks of the dirty position bitmap unit, bound to the top.
// ----------------------------------------------------------------------------
`include "dirty_position_bitmap_unit_defines.svh"

module dpb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_position_valid,
    input logic o_last_of_batch,
    input logic o_processing
);

    `DPB_ASSERT_NEXT(a_accept_resolves, i_clk, i_rst_n, start && !busy, o_done || busy, "accepted item neither finished nor held busy")
    `DPB_ASSERT_SAME(a_done_when_free, i_clk, i_rst_n, o_done, !busy, "result shown while still busy")
    `DPB_ASSERT_SAME(a_last_ends_batch, i_clk, i_rst_n, o_done && o_last_of_batch, o_position_valid && !o_processing, "last of batch without valid position or with processing set")
    `DPB_ASSERT_SAME(a_midbatch_busy, i_clk, i_rst_n, o_done && o_position_valid && !o_last_of_batch, o_processing, "position handed out mid batch but processing is clear")

endmodule

bind dirty_position_bitmap_unit dpb_checker u_dpb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_position_valid (o_position_valid),
    .o_last_of_batch  (o_last_of_batch),
    .o_processing     (o_processing)
);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Dirty position bitmap unit testbench
// Drives mark, snapshot, take and merge items through the start/busy handshake
// in random bursts and checks every result against a bit-accurate model of the
// live map, the drain copy and the ascending hand-out of dirty positions.
// ----------------------------------------------------------------------------
module testbench;
    import dpb_pkg::*;

    localparam int POSITIONS    = DEF_POSITIONS;
    localparam int NUM_WORDS    = (POSITIONS + WORD_BITS - 1) / WORD_BITS;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 16_000_000;

    typedef struct packed {
        logic [15:0] position;
        logic        pos_valid;
        logic        last_item;
        logic        processing;
        logic        live_empty;
        logic        overflow;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = '0;
    logic [15:0] i_start_req = '0;
    logic [16:0] i_count = '0;
    logic [9:0]  i_word_index = '0;
    logic [63:0] i_word_data = '0;
    logic        o_done;
    logic [15:0] o_position;
    logic        o_position_valid;
    logic        o_last_of_batch;
    logic        o_processing;
    logic        o_live_empty;
    logic        o_overflow;

    // model state
    bit [63:0] live_bits [NUM_WORDS];
    bit [63:0] drain_bits [NUM_WORDS];
    int        next_scan = 0;
    bit        drain_active = 1'b0;
    int        live_words_set = 0;
    int        drain_left = 0;

    t_outcome  expected_results[$];
    int        mismatches = 0;
    int        cycle_count = 0;

    // stimulus side bookkeeping
    int        items_sent = 0;
    int        burst_left = 1;
    int        live_guess = 0;
    int        drain_guess = 0;

    dirty_position_bitmap_unit #(.POSITIONS(POSITIONS)) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_start_req      (i_start_req),
        .i_count          (i_count),
        .i_word_index     (i_word_index),
        .i_word_data      (i_word_data),
        .o_done           (o_done),
        .o_position       (o_position),
        .o_position_valid (o_position_valid),
        .o_last_of_batch  (o_last_of_batch),
        .o_processing     (o_processing),
        .o_live_empty     (o_live_empty),
        .o_overflow       (o_overflow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void or_into_live(int w, bit [63:0] bits);
        if (live_bits[w] == '0 && bits != '0) begin
            live_words_set++;
        end
        live_bits[w] |= bits;
    endfunction

    function automatic t_outcome apply_command(t_cmd c, logic [15:0] s, logic [16:0] n,
                                               logic [9:0] idx, logic [63:0] data);
        t_outcome  r;
        int        first, stop, w0, w1, lo, hi, w, b, total;
        bit [63:0] m;
        r = '0;
        case (c)
            CMD_MARK: begin
                first = 32'(s);
                stop = first + 32'(n);
                if (n != 0) begin
                    if (stop > POSITIONS) begin
                        r.overflow = 1'b1;
                        stop = POSITIONS;
                    end
                    if (first < stop) begin
                        w0 = first / WORD_BITS;
                        w1 = (stop - 1) / WORD_BITS;
                        for (w = w0; w <= w1; w++) begin
                            lo = (w == w0) ? first % WORD_BITS : 0;
                            hi = (w == w1) ? (stop - 1) % WORD_BITS : WORD_BITS - 1;
                            m = ({64{1'b1}} << lo) & ({64{1'b1}} >> (WORD_BITS - 1 - hi));
                            or_into_live(w, m);
                        end
                    end
                end
            end
            CMD_SNAP: begin
                if (live_words_set != 0) begin
                    total = 0;
                    for (w = 0; w < NUM_WORDS; w++) begin
                        drain_bits[w] |= live_bits[w];
                        live_bits[w] = '0;
                        total += $countones(drain_bits[w]);
                    end
                    live_words_set = 0;
                    drain_left = total;
                    next_scan = 0;
                    drain_active = (total != 0);
                end
            end
            CMD_TAKE: begin
                if (drain_left != 0) begin
                    w = next_scan;
                    while (w < NUM_WORDS && drain_bits[w] == '0) w++;
                    if (w < NUM_WORDS) begin
                        b = 0;
                        while (b < 63 && !drain_bits[w][b]) b++;
                        drain_bits[w] &= drain_bits[w] - 64'd1;
                        r.position = 16'(w * WORD_BITS + b);
                        r.pos_valid = 1'b1;
                        drain_left--;
                        next_scan = w;
                    end else begin
                        drain_left = 0;
                    end
                    if (drain_left == 0) begin
                        r.last_item = r.pos_valid;
                        drain_active = 1'b0;
                        next_scan = 0;
                    end
                end else begin
                    drain_active = 1'b0;
                end
            end
            default: begin
                w = 32'(idx);
                if (w < NUM_WORDS) begin
                    if (w == NUM_WORDS - 1 && POSITIONS % WORD_BITS != 0) begin
                        m = (64'd1 << (POSITIONS % WORD_BITS)) - 64'd1;
                    end else begin
                        m = '1;
                    end
                    if ((data & ~m) != '0) begin
                        r.overflow = 1'b1;
                    end
                    or_into_live(w, data & m);
                end else if (data != '0) begin
                    r.overflow = 1'b1;
                end
            end
        endcase
        r.processing = drain_active;
        r.live_empty = (live_words_set == 0);
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // result check first, then the item accepted at this edge
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("position", want.position, o_position);
                    check_field("position_valid", 16'(want.pos_valid),
                                16'(o_position_valid));
                    check_field("last_of_batch", 16'(want.last_item),
                                16'(o_last_of_batch));
                    check_field("processing", 16'(want.processing), 16'(o_processing));
                    check_field("live_empty", 16'(want.live_empty), 16'(o_live_empty));
                    check_field("overflow", 16'(want.overflow), 16'(o_overflow));
                end
            end
            if (start && !busy) begin
                expected_results.push_back(apply_command(t_cmd'(i_cmd), i_start_req, i_count,
                                                         i_word_index, i_word_data));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(t_cmd c, logic [15:0] s, logic [16:0] n,
                             logic [9:0] idx, logic [63:0] data);
        int gap;
        start <= 1'b1;
        i_cmd <= c;
        i_start_req <= s;
        i_count <= n;
        i_word_index <= idx;
        i_word_data <= data;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 15) == 0) begin
                gap = $urandom_range(13, 60);
            end
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic do_mark(int s, int n);
        send_item(CMD_MARK, 16'(s), 17'(n), 10'($urandom), rand_word());
        live_guess += (s + n > POSITIONS) ? POSITIONS - s : n;
    endtask

    task automatic do_merge(int idx, logic [63:0] data);
        send_item(CMD_MERGE, 16'($urandom), 17'($urandom_range(0, 65536)), 10'(idx), data);
        live_guess += $countones(data);
    endtask

    task automatic do_snapshot();
        send_item(CMD_SNAP, 16'($urandom), 17'($urandom_range(0, 65536)), 10'($urandom),
                  rand_word());
        drain_guess += live_guess;
        live_guess = 0;
    endtask

    task automatic do_take(int times);
        repeat (times) begin
            send_item(CMD_TAKE, 16'($urandom), 17'($urandom_range(0, 65536)),
                      10'($urandom), rand_word());
            if (drain_guess > 0) drain_guess--;
        end
    endtask

    task automatic random_mark();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 15) begin
            do_mark($urandom_range(0, 65535), $urandom_range(1, 40));
        end else if (sel < 18) begin
            do_mark($urandom_range(0, 65535), $urandom_range(41, 300));
        end else begin
            // clipped at the top of the map, any count
            do_mark($urandom_range(POSITIONS - 64, POSITIONS - 1), $urandom_range(0, 65536));
        end
    endtask

    task automatic random_merge();
        if ($urandom_range(0, 9) == 0) begin
            do_merge($urandom_range(0, 1023), rand_word());
        end else begin
            do_merge($urandom_range(0, 1023), rand_word() & rand_word() & rand_word());
        end
    endtask

    task automatic test_idle_commands();
        do_take(1);
        do_snapshot();
        do_merge(5, 64'd0);
        do_mark(65535, 0);
    endtask

    task automatic test_mark_and_drain();
        do_mark(0, 1);
        do_mark(63, 2);
        do_mark(65534, 10);
        do_merge(1023, 64'h8000_0000_0000_0001);
        do_snapshot();
        do_take(7);
    endtask

    task automatic test_snapshot_while_busy();
        do_mark(500, 3);
        do_snapshot();
        do_take(1);
        do_mark(10, 1);
        do_snapshot();
        do_take(4);
    endtask

    task automatic test_random_traffic();
        int first_item, n_ops, n_takes;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 2) begin
                repeat ($urandom_range(3, 10)) begin
                    case ($urandom_range(0, 3))
                        0: random_mark();
                        1: do_snapshot();
                        2: do_take(1);
                        default: random_merge();
                    endcase
                end
            end else begin
                n_ops = $urandom_range(1, 4);
                repeat (n_ops) begin
                    if ($urandom_range(0, 9) < 7) random_mark();
                    else random_merge();
                end
                do_snapshot();
                if ($urandom_range(0, 3) == 0) begin
                    n_takes = drain_guess / 2;
                end else begin
                    n_takes = drain_guess + $urandom_range(0, 2);
                end
                do_take(n_takes);
            end
        end
    endtask

    task automatic test_full_capacity();
        do_mark(0, 65536);
        do_mark(1, 65535);
        do_mark(65535, 65536);
        do_merge(1023, '1);
        do_snapshot();
        do_take(2);
        do_mark(0, 65536);
        do_snapshot();
        do_take(1);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_commands();
        test_mark_and_drain();
        test_snapshot_while_busy();
        test_random_traffic();
        test_full_capacity();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* dirty_position_bitmap_unit.f */
+incdir+design
design/dpb_pkg.sv
design/dpb_ram.sv
design/dpb_ctrl.sv
design/dirty_position_bitmap_unit.sv
design/dpb_checker.sv
bench/testbench.sv
